// File: rtl/gsig_pkg.sv
// shared widths, register indexes, reset sizes and emit phase codes for the strip index generator
package gsig_pkg;

  localparam int unsigned IDX_W     = 23;
  localparam int unsigned LVL_W     = 4;
  localparam int unsigned QLOG_W    = 3;
  localparam int unsigned GLOG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_LOG2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LOG2 = 1'b1;

  localparam logic [QLOG_W-1:0] QUAD_LOG2_RST = 3'd4;
  localparam logic [GLOG_W-1:0] GRID_LOG2_RST = 4'd3;

  localparam int unsigned PH_W = 2;
  localparam logic [PH_W-1:0] PH_UPPER = 2'd0;
  localparam logic [PH_W-1:0] PH_LOWER = 2'd1;
  localparam logic [PH_W-1:0] PH_JOIN1 = 2'd2;
  localparam logic [PH_W-1:0] PH_JOIN2 = 2'd3;

endpackage

// File: rtl/grid_strip_index_generator.sv
// Terrain patch strip index generator: one vertex index per item, with
// degenerate joins between rows and level of detail tags. Every accepted item
// yields exactly one index, and an item can be accepted on every clock cycle
// while the output is not stalled: the column, row, phase, level, row base and
// pitch counters step together and the index lands in the output register, so the
// sustained rate is one index per cycle while the output is not stalled.
// A restart item returns to the first index of level 0 and emits it at once.
// Writing either size register also returns the sequence to its start.
module grid_strip_index_generator #(
  parameter int unsigned MAX_QUAD_LOG2 = 7,
  parameter int unsigned MAX_GRID_LOG2 = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gsig_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gsig_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gsig_pkg::IDX_W-1:0]       vertex_index_o,
  output logic [gsig_pkg::LVL_W-1:0]       detail_level_o,
  output logic                             level_last_o,
  output logic                             sequence_last_o
);

  localparam int unsigned COL_W   = MAX_QUAD_LOG2 + 1;
  localparam int unsigned ROW_W   = MAX_QUAD_LOG2;
  localparam int unsigned QE_W    = $clog2(MAX_QUAD_LOG2 + 1);
  localparam int unsigned GE_W    = $clog2(MAX_GRID_LOG2 + 1);
  localparam int unsigned SUM_W   = $clog2(MAX_QUAD_LOG2 + MAX_GRID_LOG2 + 1);
  localparam int unsigned PITCH_W = MAX_QUAD_LOG2 + MAX_GRID_LOG2 + 1;
  localparam int unsigned IDX_W   = gsig_pkg::IDX_W;
  localparam int unsigned LVL_W   = gsig_pkg::LVL_W;

  logic [gsig_pkg::QLOG_W-1:0] quad_log2_q;
  logic [gsig_pkg::GLOG_W-1:0] grid_log2_q;

  logic [COL_W-1:0]          col_q, col_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [gsig_pkg::PH_W-1:0] phase_q, phase_d;
  logic [LVL_W-1:0]          level_q, level_d;
  logic [IDX_W-1:0]          base_q, base_d;
  logic [PITCH_W-1:0]        pitch_q, pitch_d;

  logic                      out_valid_q;
  logic [IDX_W-1:0]          vertex_index_q;
  logic [LVL_W-1:0]          detail_level_q;
  logic                      level_last_q;
  logic                      sequence_last_q;

  logic                      in_acc;
  logic [QE_W-1:0]           q_eff;
  logic [GE_W-1:0]           g_eff;
  logic [COL_W-1:0]          quad;
  logic [SUM_W-1:0]          size_log2;
  logic [COL_W-1:0]          col_cur;
  logic [ROW_W-1:0]          row_cur;
  logic [gsig_pkg::PH_W-1:0] phase_cur;
  logic [LVL_W-1:0]          lvl_cur;
  logic [IDX_W-1:0]          base_cur;
  logic [PITCH_W-1:0]        pitch_cur;
  logic [IDX_W-1:0]          lower_row;
  logic                      strip_start;
  logic [IDX_W-1:0]          idx_d;
  logic                      lvl_last_d;
  logic                      seq_last_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // oversized registers are clamped to the supported grid
  always_comb begin
    if (int'(quad_log2_q) > MAX_QUAD_LOG2) begin
      q_eff = QE_W'(MAX_QUAD_LOG2);
    end else begin
      q_eff = QE_W'(quad_log2_q);
    end
    if (int'(grid_log2_q) > MAX_GRID_LOG2) begin
      g_eff = GE_W'(MAX_GRID_LOG2);
    end else begin
      g_eff = GE_W'(grid_log2_q);
    end
  end

  assign quad      = COL_W'(1) << q_eff;
  assign size_log2 = SUM_W'(q_eff) + SUM_W'(g_eff);

  always_comb begin
    col_cur   = col_q;
    row_cur   = row_q;
    phase_cur = phase_q;
    lvl_cur   = level_q;
    base_cur  = base_q;
    pitch_cur = pitch_q;
    if (restart_i) begin
      col_cur   = '0;
      row_cur   = '0;
      phase_cur = gsig_pkg::PH_UPPER;
      lvl_cur   = '0;
      base_cur  = '0;
      pitch_cur = '0;
    end
    if (lvl_cur > LVL_W'(g_eff)) begin
      lvl_cur = '0;
    end
    strip_start = (col_cur == '0) && (row_cur == '0) && (phase_cur == gsig_pkg::PH_UPPER);
    // pitch of the level is loaded on its first index
    if (strip_start) begin
      pitch_cur = (((PITCH_W'(1) << size_log2) + PITCH_W'(1)) >> lvl_cur) | PITCH_W'(1);
      base_cur  = '0;
    end
  end

  assign lower_row = base_cur + IDX_W'(pitch_cur);

  always_comb begin
    col_d      = col_cur;
    row_d      = row_cur;
    phase_d    = phase_cur;
    level_d    = lvl_cur;
    base_d     = base_cur;
    pitch_d    = pitch_cur;
    lvl_last_d = 1'b0;
    seq_last_d = 1'b0;
    case (phase_cur)
      gsig_pkg::PH_UPPER: begin
        idx_d   = base_cur + IDX_W'(col_cur);
        phase_d = gsig_pkg::PH_LOWER;
      end
      gsig_pkg::PH_LOWER: begin
        idx_d = lower_row + IDX_W'(col_cur);
        if (col_cur >= quad) begin
          if ((COL_W'(row_cur) + COL_W'(1)) >= quad) begin
            lvl_last_d = 1'b1;
          end else begin
            phase_d = gsig_pkg::PH_JOIN1;
            col_d   = '0;
          end
        end else begin
          col_d   = col_cur + COL_W'(1);
          phase_d = gsig_pkg::PH_UPPER;
        end
      end
      gsig_pkg::PH_JOIN1: begin
        idx_d   = lower_row + IDX_W'(quad);
        phase_d = gsig_pkg::PH_JOIN2;
      end
      default: begin
        idx_d   = lower_row;
        base_d  = lower_row;
        row_d   = row_cur + ROW_W'(1);
        col_d   = '0;
        phase_d = gsig_pkg::PH_UPPER;
      end
    endcase
    if (lvl_last_d) begin
      if (lvl_cur >= LVL_W'(g_eff)) begin
        seq_last_d = 1'b1;
        level_d    = '0;
      end else begin
        level_d = lvl_cur + LVL_W'(1);
      end
      col_d   = '0;
      row_d   = '0;
      phase_d = gsig_pkg::PH_UPPER;
      base_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_log2_q <= gsig_pkg::QUAD_LOG2_RST;
      grid_log2_q <= gsig_pkg::GRID_LOG2_RST;
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= gsig_pkg::PH_UPPER;
      level_q     <= '0;
      base_q      <= '0;
      pitch_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gsig_pkg::CFG_QUAD_LOG2: quad_log2_q <= cfg_data_i[gsig_pkg::QLOG_W-1:0];
        gsig_pkg::CFG_GRID_LOG2: grid_log2_q <= cfg_data_i;
        default: ;
      endcase
      // a size change restarts the strip
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= gsig_pkg::PH_UPPER;
      level_q <= '0;
      base_q  <= '0;
      pitch_q <= '0;
    end else if (in_acc) begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      level_q <= level_d;
      base_q  <= base_d;
      pitch_q <= pitch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vertex_index_q  <= idx_d;
      detail_level_q  <= lvl_cur;
      level_last_q    <= lvl_last_d;
      sequence_last_q <= seq_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_index_o  = vertex_index_q;
  assign detail_level_o  = detail_level_q;
  assign level_last_o    = level_last_q;
  assign sequence_last_o = sequence_last_q;

  a_seq_last_is_level_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sequence_last_o |-> level_last_o)
    else $error("sequence end without level end");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> detail_level_o <= LVL_W'(g_eff))
    else $error("detail level beyond grid levels");

  a_level_end_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_we_i && lvl_last_d |=>
      col_q == '0 && row_q == '0 && phase_q == gsig_pkg::PH_UPPER && base_q == '0)
    else $error("strip counters not rewound after level end");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

endmodule
